>>> design/ldp_pkg.sv
// Shared constants, types and rounding helpers for the lens distortion projection.
package ldp_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 48;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SKEW      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K1 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K2 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TANG_P1   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TANG_P2   = 4'd7;

    // Reset values of the focal registers (1.0 in Q16.8).
    localparam logic [23:0] FOCAL_RESET = 24'd256;

    // One in Q.16, at the width of the radial gain.
    localparam logic signed [35:0] Q16_ONE = 36'sd65536;

    // A clipped 32 bit output and whether clipping happened.
    typedef struct packed {
        logic              clip;
        logic signed [31:0] val;
    } t_sat;

    // Drop 16 fraction bits, rounding half toward plus infinity.
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        rnd16 = (v + 64'sd32768) >>> 16;
    endfunction

    // Drop 20 fraction bits, rounding half toward plus infinity.
    function automatic logic signed [63:0] rnd20(input logic signed [63:0] v);
        rnd20 = (v + 64'sd524288) >>> 20;
    endfunction

    // Clip to the signed 32 bit range and flag it.
    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat res;
        res.clip = 1'b0;
        res.val  = v[31:0];
        if (v > 64'sd2147483647) begin
            res.clip = 1'b1;
            res.val  = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res.clip = 1'b1;
            res.val  = 32'sh80000000;
        end
        sat32 = res;
    endfunction

endpackage

>>> design/lens_distortion_projection.sv
// Top level of the lens distortion projection: eight stage arithmetic pipeline.
//
// Usage notes.
// The input channel carries one normalized point (signed Q4.16 x and y) per beat;
// the output channel carries the distorted pixel (signed Q23.8 u and v), the four
// entries of the 2x2 point Jacobian (signed Q23.8) and a saturation flag per beat.
// Every input beat gives exactly one output beat, in order.
// The pipeline has eight register stages, and one point can be accepted in every
// cycle while the output does not stall. The depth is set by the chain of dependent
// multiplies (r^2, r^4, radial gain, gain times point, Jacobian terms, intrinsic
// matrix).
// Each stage holds its beat until the next stage can take it, so a stall on the
// output fills the empty stages first; the input stalls only when the stage
// behind it is full and cannot move. Nothing is lost or repeated under stall.
// The configuration channel is always ready; registers should be written only
// while the pipeline is empty. Reset empties the pipeline and sets both focal
// lengths to 1.0 and all other registers to zero; there is no clearing pass.
module lens_distortion_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ldp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ldp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input point channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [19:0]                  i_normalized_x,
    input  logic signed [19:0]                  i_normalized_y,
    // Output pixel channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_pixel_u,
    output logic signed [31:0]                  o_pixel_v,
    output logic signed [31:0]                  o_jac_u_x,
    output logic signed [31:0]                  o_jac_u_y,
    output logic signed [31:0]                  o_jac_v_x,
    output logic signed [31:0]                  o_jac_v_y,
    output logic                                o_saturated
);
    import ldp_pkg::*;

    localparam int unsigned NSTAGE = 8;

    // Configuration registers.
    logic        [23:0] r_focal_x;
    logic        [23:0] r_focal_y;
    logic signed [24:0] r_skew;
    logic        [47:0] r_pp;
    logic signed [23:0] r_k1;
    logic signed [23:0] r_k2;
    logic signed [23:0] r_p1;
    logic signed [23:0] r_p2;

    // Pipeline control.
    logic [NSTAGE:1] r_vld;
    logic [NSTAGE:1] w_en;
    logic            w_acc_in;
    logic            w_acc_out;

    // Stage 1: squares, cross term and the terms linear in the point.
    logic signed [20:0] w_s1_x2, w_s1_y2, w_s1_none;
    logic signed [22:0] w_s1_x6, w_s1_y6;
    logic signed [39:0] w_s1_mxx, w_s1_myy, w_s1_mxy;
    logic signed [44:0] w_s1_mp1y2, w_s1_mp1x2, w_s1_mp2y2, w_s1_mp2x2;
    logic signed [46:0] w_s1_mp2x6, w_s1_mp1y6;
    logic signed [23:0] n_s1_xx, n_s1_yy, n_s1_xy;
    logic signed [27:0] n_s1_la00, n_s1_la01, n_s1_la11;
    logic signed [19:0] r_s1_x, r_s1_y;
    logic signed [23:0] r_s1_xx, r_s1_yy, r_s1_xy;
    logic signed [27:0] r_s1_la00, r_s1_la01, r_s1_la11;

    // Stage 2: radius squared, tangential sums and cross products.
    logic signed [24:0] n_s2_rr, w_s2_xy2;
    logic signed [25:0] n_s2_sx, n_s2_sy;
    logic signed [48:0] w_s2_mp1xy, w_s2_mp2xy;
    logic signed [27:0] n_s2_qx, n_s2_qy;
    logic signed [19:0] r_s2_x, r_s2_y;
    logic signed [24:0] r_s2_rr;
    logic signed [25:0] r_s2_sx, r_s2_sy;
    logic signed [27:0] r_s2_qx, r_s2_qy;
    logic signed [27:0] r_s2_la00, r_s2_la01, r_s2_la11;

    // Stage 3: fourth power, radial products and tangential offsets.
    logic signed [49:0] w_s3_mrr;
    logic signed [48:0] w_s3_mk1rr, w_s3_mk2rr;
    logic signed [49:0] w_s3_mp2sx, w_s3_mp1sy;
    logic signed [31:0] n_s3_r4, n_s3_m2;
    logic signed [27:0] n_s3_m1;
    logic signed [29:0] n_s3_dx, n_s3_dy;
    logic signed [19:0] r_s3_x, r_s3_y;
    logic signed [31:0] r_s3_r4, r_s3_m2;
    logic signed [27:0] r_s3_m1;
    logic signed [29:0] r_s3_dx, r_s3_dy;
    logic signed [27:0] r_s3_la00, r_s3_la01, r_s3_la11;

    // Stage 4: radial gain and its slope factor.
    logic signed [55:0] w_s4_mk2r4;
    logic signed [35:0] n_s4_g;
    logic signed [33:0] n_s4_c;
    logic signed [19:0] r_s4_x, r_s4_y;
    logic signed [35:0] r_s4_g;
    logic signed [33:0] r_s4_c;
    logic signed [29:0] r_s4_dx, r_s4_dy;
    logic signed [27:0] r_s4_la00, r_s4_la01, r_s4_la11;

    // Stage 5: distorted point and gain gradient.
    logic signed [55:0] w_s5_mgx, w_s5_mgy;
    logic signed [20:0] w_s5_x2, w_s5_y2;
    logic signed [54:0] w_s5_mcx, w_s5_mcy;
    logic signed [37:0] n_s5_px, n_s5_py;
    logic signed [33:0] n_s5_gx, n_s5_gy;
    logic signed [19:0] r_s5_x, r_s5_y;
    logic signed [35:0] r_s5_g;
    logic signed [37:0] r_s5_px, r_s5_py;
    logic signed [33:0] r_s5_gx, r_s5_gy;
    logic signed [27:0] r_s5_la00, r_s5_la01, r_s5_la11;

    // Stage 6: Jacobian of the distorted point.
    logic signed [53:0] w_s6_mxgx, w_s6_mxgy, w_s6_mygx, w_s6_mygy;
    logic signed [37:0] n_s6_a00, n_s6_a01, n_s6_a10, n_s6_a11;
    logic signed [37:0] r_s6_px, r_s6_py;
    logic signed [37:0] r_s6_a00, r_s6_a01, r_s6_a10, r_s6_a11;

    // Stage 7: intrinsic matrix products.
    logic signed [24:0] w_fx, w_fy;
    logic signed [62:0] r_s7_fpx, r_s7_spy, r_s7_fypy;
    logic signed [62:0] r_s7_fa00, r_s7_sa10, r_s7_fa01, r_s7_sa11;
    logic signed [62:0] r_s7_fya10, r_s7_fya11;

    // Stage 8: rounding, principal point and saturation.
    logic signed [63:0] w_u0, w_v0;
    logic signed [63:0] w_s8_u, w_s8_v, w_s8_ux, w_s8_uy, w_s8_vx, w_s8_vy;
    t_sat               w_sat_u, w_sat_v, w_sat_ux, w_sat_uy, w_sat_vx, w_sat_vy;
    logic signed [31:0] r_s8_u, r_s8_v, r_s8_ux, r_s8_uy, r_s8_vx, r_s8_vy;
    logic               r_s8_sat;

    // Configuration writes; indexes past the last register are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= FOCAL_RESET;
            r_focal_y <= FOCAL_RESET;
            r_skew    <= '0;
            r_pp      <= '0;
            r_k1      <= '0;
            r_k2      <= '0;
            r_p1      <= '0;
            r_p2      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FOCAL_X:   r_focal_x <= i_cfg_data[23:0];
                REG_FOCAL_Y:   r_focal_y <= i_cfg_data[23:0];
                REG_SKEW:      r_skew    <= i_cfg_data[24:0];
                REG_PRINCIPAL: r_pp      <= i_cfg_data[47:0];
                REG_RADIAL_K1: r_k1      <= i_cfg_data[23:0];
                REG_RADIAL_K2: r_k2      <= i_cfg_data[23:0];
                REG_TANG_P1:   r_p1      <= i_cfg_data[23:0];
                REG_TANG_P2:   r_p2      <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NSTAGE] = !r_vld[NSTAGE] || !i_out_stall;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_stall  = !w_en[1];
    assign o_out_valid = r_vld[NSTAGE];
    assign w_acc_in    = i_in_valid && !o_in_stall;
    assign w_acc_out   = o_out_valid && !i_out_stall;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1 logic: x^2, y^2, xy and the tangential terms linear in the point.
    // The linear terms of the off-diagonal Jacobian entries are identical.
    always_comb begin
        w_s1_x2    = i_normalized_x * 21'sd2;
        w_s1_y2    = i_normalized_y * 21'sd2;
        w_s1_none  = '0;
        w_s1_x6    = i_normalized_x * 23'sd6;
        w_s1_y6    = i_normalized_y * 23'sd6;
        w_s1_mxx   = i_normalized_x * i_normalized_x;
        w_s1_myy   = i_normalized_y * i_normalized_y;
        w_s1_mxy   = i_normalized_x * i_normalized_y;
        w_s1_mp1y2 = r_p1 * w_s1_y2;
        w_s1_mp1x2 = r_p1 * w_s1_x2;
        w_s1_mp2y2 = r_p2 * w_s1_y2;
        w_s1_mp2x2 = r_p2 * w_s1_x2;
        w_s1_mp2x6 = r_p2 * w_s1_x6;
        w_s1_mp1y6 = r_p1 * w_s1_y6;
        n_s1_xx    = 24'(rnd16(64'(w_s1_mxx)));
        n_s1_yy    = 24'(rnd16(64'(w_s1_myy)));
        n_s1_xy    = 24'(rnd16(64'(w_s1_mxy)));
        n_s1_la00  = 28'(rnd20(64'(w_s1_mp1y2))) + 28'(rnd20(64'(w_s1_mp2x6)));
        n_s1_la01  = 28'(rnd20(64'(w_s1_mp1x2))) + 28'(rnd20(64'(w_s1_mp2y2)))
                   + 28'(w_s1_none);
        n_s1_la11  = 28'(rnd20(64'(w_s1_mp2x2))) + 28'(rnd20(64'(w_s1_mp1y6)));
    end

    // Stage 2 logic: r^2 = x^2 + y^2, r^2 + 2x^2, r^2 + 2y^2 and 2p*xy.
    always_comb begin
        n_s2_rr    = 25'(r_s1_xx) + 25'(r_s1_yy);
        n_s2_sx    = 26'(n_s2_rr) + 26'(r_s1_xx) + 26'(r_s1_xx);
        n_s2_sy    = 26'(n_s2_rr) + 26'(r_s1_yy) + 26'(r_s1_yy);
        w_s2_xy2   = 25'(r_s1_xy) + 25'(r_s1_xy);
        w_s2_mp1xy = r_p1 * w_s2_xy2;
        w_s2_mp2xy = r_p2 * w_s2_xy2;
        n_s2_qx    = 28'(rnd20(64'(w_s2_mp1xy)));
        n_s2_qy    = 28'(rnd20(64'(w_s2_mp2xy)));
    end

    // Stage 3 logic: r^4, k1*r^2, k2*r^2 and the tangential offsets.
    always_comb begin
        w_s3_mrr   = r_s2_rr * r_s2_rr;
        w_s3_mk1rr = r_k1 * r_s2_rr;
        w_s3_mk2rr = r_k2 * r_s2_rr;
        w_s3_mp2sx = r_p2 * r_s2_sx;
        w_s3_mp1sy = r_p1 * r_s2_sy;
        n_s3_r4    = 32'(rnd16(64'(w_s3_mrr)));
        n_s3_m1    = 28'(rnd20(64'(w_s3_mk1rr)));
        n_s3_m2    = 32'(rnd16(64'(w_s3_mk2rr)));
        n_s3_dx    = 30'(r_s2_qx) + 30'(rnd20(64'(w_s3_mp2sx)));
        n_s3_dy    = 30'(r_s2_qy) + 30'(rnd20(64'(w_s3_mp1sy)));
    end

    // Stage 4 logic: gain g = 1 + k1*r^2 + k2*r^4 and slope c = k1 + 2*k2*r^2.
    always_comb begin
        w_s4_mk2r4 = r_k2 * r_s3_r4;
        n_s4_g     = Q16_ONE + 36'(r_s3_m1) + 36'(rnd20(64'(w_s4_mk2r4)));
        n_s4_c     = 34'(r_k1) + 34'(r_s3_m2) + 34'(r_s3_m2);
    end

    // Stage 5 logic: distorted point g*p + d and gain gradient c*2p.
    always_comb begin
        w_s5_mgx = r_s4_g * r_s4_x;
        w_s5_mgy = r_s4_g * r_s4_y;
        w_s5_x2  = r_s4_x * 21'sd2;
        w_s5_y2  = r_s4_y * 21'sd2;
        w_s5_mcx = r_s4_c * w_s5_x2;
        w_s5_mcy = r_s4_c * w_s5_y2;
        n_s5_px  = 38'(rnd16(64'(w_s5_mgx))) + 38'(r_s4_dx);
        n_s5_py  = 38'(rnd16(64'(w_s5_mgy))) + 38'(r_s4_dy);
        n_s5_gx  = 34'(rnd20(64'(w_s5_mcx)));
        n_s5_gy  = 34'(rnd20(64'(w_s5_mcy)));
    end

    // Stage 6 logic: Jacobian entries of the distorted point.
    always_comb begin
        w_s6_mxgx = r_s5_x * r_s5_gx;
        w_s6_mxgy = r_s5_x * r_s5_gy;
        w_s6_mygx = r_s5_y * r_s5_gx;
        w_s6_mygy = r_s5_y * r_s5_gy;
        n_s6_a00  = 38'(r_s5_g) + 38'(rnd16(64'(w_s6_mxgx))) + 38'(r_s5_la00);
        n_s6_a01  = 38'(rnd16(64'(w_s6_mxgy))) + 38'(r_s5_la01);
        n_s6_a10  = 38'(rnd16(64'(w_s6_mygx))) + 38'(r_s5_la01);
        n_s6_a11  = 38'(r_s5_g) + 38'(rnd16(64'(w_s6_mygy))) + 38'(r_s5_la11);
    end

    // Focal lengths as signed multiplier operands, principal point as offsets.
    assign w_fx = {1'b0, r_focal_x};
    assign w_fy = {1'b0, r_focal_y};
    assign w_u0 = {40'd0, r_pp[23:0]};
    assign w_v0 = {40'd0, r_pp[47:24]};

    // Stage 8 logic: row sums, rounding, principal point and clipping.
    always_comb begin
        w_s8_u   = rnd16(64'(r_s7_fpx) + 64'(r_s7_spy)) + w_u0;
        w_s8_v   = rnd16(64'(r_s7_fypy)) + w_v0;
        w_s8_ux  = rnd16(64'(r_s7_fa00) + 64'(r_s7_sa10));
        w_s8_uy  = rnd16(64'(r_s7_fa01) + 64'(r_s7_sa11));
        w_s8_vx  = rnd16(64'(r_s7_fya10));
        w_s8_vy  = rnd16(64'(r_s7_fya11));
        w_sat_u  = sat32(w_s8_u);
        w_sat_v  = sat32(w_s8_v);
        w_sat_ux = sat32(w_s8_ux);
        w_sat_uy = sat32(w_s8_uy);
        w_sat_vx = sat32(w_s8_vx);
        w_sat_vy = sat32(w_s8_vy);
    end

    // Pipeline data registers; each stage loads together with its valid bit.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_x    <= i_normalized_x;
            r_s1_y    <= i_normalized_y;
            r_s1_xx   <= n_s1_xx;
            r_s1_yy   <= n_s1_yy;
            r_s1_xy   <= n_s1_xy;
            r_s1_la00 <= n_s1_la00;
            r_s1_la01 <= n_s1_la01;
            r_s1_la11 <= n_s1_la11;
        end
        if (w_en[2]) begin
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_rr   <= n_s2_rr;
            r_s2_sx   <= n_s2_sx;
            r_s2_sy   <= n_s2_sy;
            r_s2_qx   <= n_s2_qx;
            r_s2_qy   <= n_s2_qy;
            r_s2_la00 <= r_s1_la00;
            r_s2_la01 <= r_s1_la01;
            r_s2_la11 <= r_s1_la11;
        end
        if (w_en[3]) begin
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
            r_s3_r4   <= n_s3_r4;
            r_s3_m1   <= n_s3_m1;
            r_s3_m2   <= n_s3_m2;
            r_s3_dx   <= n_s3_dx;
            r_s3_dy   <= n_s3_dy;
            r_s3_la00 <= r_s2_la00;
            r_s3_la01 <= r_s2_la01;
            r_s3_la11 <= r_s2_la11;
        end
        if (w_en[4]) begin
            r_s4_x    <= r_s3_x;
            r_s4_y    <= r_s3_y;
            r_s4_g    <= n_s4_g;
            r_s4_c    <= n_s4_c;
            r_s4_dx   <= r_s3_dx;
            r_s4_dy   <= r_s3_dy;
            r_s4_la00 <= r_s3_la00;
            r_s4_la01 <= r_s3_la01;
            r_s4_la11 <= r_s3_la11;
        end
        if (w_en[5]) begin
            r_s5_x    <= r_s4_x;
            r_s5_y    <= r_s4_y;
            r_s5_g    <= r_s4_g;
            r_s5_px   <= n_s5_px;
            r_s5_py   <= n_s5_py;
            r_s5_gx   <= n_s5_gx;
            r_s5_gy   <= n_s5_gy;
            r_s5_la00 <= r_s4_la00;
            r_s5_la01 <= r_s4_la01;
            r_s5_la11 <= r_s4_la11;
        end
        if (w_en[6]) begin
            r_s6_px  <= r_s5_px;
            r_s6_py  <= r_s5_py;
            r_s6_a00 <= n_s6_a00;
            r_s6_a01 <= n_s6_a01;
            r_s6_a10 <= n_s6_a10;
            r_s6_a11 <= n_s6_a11;
        end
        if (w_en[7]) begin
            r_s7_fpx   <= w_fx * r_s6_px;
            r_s7_spy   <= r_skew * r_s6_py;
            r_s7_fypy  <= w_fy * r_s6_py;
            r_s7_fa00  <= w_fx * r_s6_a00;
            r_s7_sa10  <= r_skew * r_s6_a10;
            r_s7_fa01  <= w_fx * r_s6_a01;
            r_s7_sa11  <= r_skew * r_s6_a11;
            r_s7_fya10 <= w_fy * r_s6_a10;
            r_s7_fya11 <= w_fy * r_s6_a11;
        end
        if (w_en[8]) begin
            r_s8_u   <= w_sat_u.val;
            r_s8_v   <= w_sat_v.val;
            r_s8_ux  <= w_sat_ux.val;
            r_s8_uy  <= w_sat_uy.val;
            r_s8_vx  <= w_sat_vx.val;
            r_s8_vy  <= w_sat_vy.val;
            r_s8_sat <= w_sat_u.clip || w_sat_v.clip || w_sat_ux.clip
                     || w_sat_uy.clip || w_sat_vx.clip || w_sat_vy.clip;
        end
    end

    // Output register drives the result beat.
    assign o_pixel_u   = r_s8_u;
    assign o_pixel_v   = r_s8_v;
    assign o_jac_u_x   = r_s8_ux;
    assign o_jac_u_y   = r_s8_uy;
    assign o_jac_v_x   = r_s8_vx;
    assign o_jac_v_y   = r_s8_vy;
    assign o_saturated = r_s8_sat;

    // With every stage full and the output held, the input must be held too.
    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && i_out_stall) |-> o_in_stall)
        else $error("input taken while the pipeline is full and stalled");

    // Without an output stall the pipeline always moves and takes input.
    a_no_stall_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled although the output is not stalled");

    // Beats in flight change only by accepted inputs and delivered outputs.
    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) ==
                  $past($countones(r_vld)) + $past(w_acc_in) - $past(w_acc_out)))
        else $error("beat lost or duplicated inside the pipeline");

endmodule
